### sv/msbs_pkg.sv
// shared types and constants for the multi-signature byte scanner
package msbs_pkg;

   localparam int MODE_W  = 2;
   localparam int BYTE_W  = 8;
   localparam int OFF_W   = 14;
   localparam int SIDX_W  = 4;

   localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SCAN   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_NEWBUF = 2'd2;

   // history window control from the sequencer
   typedef struct packed {
      logic              shift;
      logic              clear;
      logic [BYTE_W-1:0] data;
   } hist_ctl_type;

endpackage

### sv/multi_signature_byte_scanner_core.sv
// top level: signature loader, scan sequencer and result register
//
//   port group  direction  handshake             payload
//   req_        in         req_valid/req_ready   mode, byte_value, sig_end
//   rsp_        out        rsp_valid/rsp_ready   match_offset, signature_index, last
//
// load, new-buffer and ignored words leave the core ready, as does a data word with no signatures
// otherwise a data word moves the core to its scan state, where one stored signature is read and compared
// per cycle, unless stalled, by the single row comparator behind the signature memory
// a held result stalls the comparator only when a second match is ready
// synchronous active-high reset clears all control state and the history window
module multi_signature_byte_scanner_core #(
   parameter int MAX_SIGNATURES = 16,
   parameter int MAX_SIG_LEN    = 64,
   parameter int MAX_BUFFER     = 16384
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [msbs_pkg::MODE_W-1:0]  req_mode,
   input  logic [msbs_pkg::BYTE_W-1:0]  req_byte_value,
   input  logic                         req_sig_end,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [msbs_pkg::OFF_W-1:0]   rsp_match_offset,
   output logic [msbs_pkg::SIDX_W-1:0]  rsp_signature_index,
   output logic                         rsp_last
);
   import msbs_pkg::*;

   localparam int ROW_W   = MAX_SIG_LEN * BYTE_W;
   localparam int IDX_W   = (MAX_SIGNATURES > 1) ? $clog2(MAX_SIGNATURES) : 1;
   localparam int CNT_W   = $clog2(MAX_SIGNATURES + 1);
   localparam int LEN_W   = $clog2(MAX_SIG_LEN + 1);
   localparam int POS_W   = $clog2(MAX_BUFFER + 1);
   localparam int CMP_W   = (POS_W > LEN_W) ? POS_W : LEN_W;
   localparam int OFFC_W  = (POS_W > OFF_W) ? POS_W : OFF_W;
   localparam int IDXC_W  = (IDX_W > SIDX_W) ? IDX_W : SIDX_W;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_SCAN = 1'b1;

   logic                state_ff,     state_in;
   logic [CNT_W-1:0]    count_ff,     count_in;
   logic [LEN_W-1:0]    load_pos_ff,  load_pos_in;
   logic [ROW_W-1:0]    row_ff,       row_in;
   logic [POS_W-1:0]    scan_ff,      scan_in;
   logic [LEN_W-1:0]    len_ff [MAX_SIGNATURES];
   logic [CNT_W-1:0]    issue_ff,     issue_in;
   logic                cmp_valid_ff, cmp_valid_in;
   logic [IDX_W-1:0]    cmp_idx_ff,   cmp_idx_in;
   logic                hold_valid_ff, hold_valid_in;
   logic [OFF_W-1:0]    hold_off_ff,  hold_off_in;
   logic [SIDX_W-1:0]   hold_idx_ff,  hold_idx_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [OFF_W-1:0]    rsp_off_ff;
   logic [SIDX_W-1:0]   rsp_idx_ff;
   logic                rsp_last_ff;

   logic                accept;
   logic                do_load;
   logic                keep;
   logic [ROW_W-1:0]    row_next;
   logic [LEN_W-1:0]    pos_next;
   logic                len_wr;
   logic                ram_wr;
   logic                ram_rd;
   logic [ROW_W-1:0]    ram_rdata;
   hist_ctl_type        hist_ctl;
   logic                bytes_hit;
   logic [LEN_W-1:0]    cur_len;
   logic                len_ok;
   logic                hit;
   logic                out_free;
   logic                stall;
   logic                issue_more;
   logic [OFFC_W-1:0]   start_wide;
   logic [IDXC_W-1:0]   idx_wide;
   logic                emit;
   logic [OFF_W-1:0]    emit_off;
   logic [SIDX_W-1:0]   emit_idx;
   logic                emit_last;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // signature loading
   assign do_load  = accept && (req_mode == MODE_LOAD) &&
                     (count_ff < CNT_W'(MAX_SIGNATURES));
   assign keep     = load_pos_ff < LEN_W'(MAX_SIG_LEN);
   assign row_next = keep ? ROW_W'({row_ff, req_byte_value}) : row_ff;
   assign pos_next = load_pos_ff + LEN_W'(keep);
   assign ram_wr   = do_load && req_sig_end;
   assign len_wr   = ram_wr;

   // scan bookkeeping
   assign cur_len    = len_ff[cmp_idx_ff];
   assign len_ok     = (cur_len != '0) && (CMP_W'(cur_len) <= CMP_W'(scan_ff));
   assign hit        = cmp_valid_ff && len_ok && bytes_hit;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign stall      = hit && hold_valid_ff && !out_free;
   assign issue_more = issue_ff < count_ff;
   assign start_wide = OFFC_W'(scan_ff) - OFFC_W'(cur_len);
   assign idx_wide   = IDXC_W'(cmp_idx_ff);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      load_pos_in   = load_pos_ff;
      row_in        = row_ff;
      scan_in       = scan_ff;
      issue_in      = issue_ff;
      cmp_valid_in  = cmp_valid_ff;
      cmp_idx_in    = cmp_idx_ff;
      hold_valid_in = hold_valid_ff;
      hold_off_in   = hold_off_ff;
      hold_idx_in   = hold_idx_ff;
      ram_rd        = 1'b0;
      emit          = 1'b0;
      emit_off      = hold_off_ff;
      emit_idx      = hold_idx_ff;
      emit_last     = 1'b0;
      hist_ctl      = '{shift: 1'b0, clear: 1'b0, data: req_byte_value};

      case (state_ff)
         ST_IDLE: begin
            if (do_load) begin
               if (req_sig_end) begin
                  count_in    = count_ff + CNT_W'(1);
                  load_pos_in = '0;
               end else begin
                  load_pos_in = pos_next;
                  row_in      = row_next;
               end
            end
            if (accept && (req_mode == MODE_NEWBUF)) begin
               scan_in       = '0;
               hist_ctl.clear = 1'b1;
            end
            if (accept && (req_mode == MODE_SCAN) &&
                (scan_ff < POS_W'(MAX_BUFFER))) begin
               scan_in        = scan_ff + POS_W'(1);
               hist_ctl.shift = 1'b1;
               issue_in       = '0;
               cmp_valid_in   = 1'b0;
               hold_valid_in  = 1'b0;
               if (count_ff != '0) begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (!cmp_valid_ff && !issue_more) begin
               if (!hold_valid_ff) begin
                  state_in = ST_IDLE;
               end else if (out_free) begin
                  emit          = 1'b1;
                  emit_last     = 1'b1;
                  hold_valid_in = 1'b0;
                  state_in      = ST_IDLE;
               end
            end else if (!stall) begin
               ram_rd       = issue_more;
               cmp_valid_in = issue_more;
               cmp_idx_in   = issue_ff[IDX_W-1:0];
               issue_in     = issue_ff + CNT_W'(issue_more);
               if (hit) begin
                  emit          = hold_valid_ff;
                  hold_valid_in = 1'b1;
                  hold_off_in   = start_wide[OFF_W-1:0];
                  hold_idx_in   = idx_wide[SIDX_W-1:0];
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         load_pos_ff   <= '0;
         scan_ff       <= '0;
         issue_ff      <= '0;
         cmp_valid_ff  <= 1'b0;
         cmp_idx_ff    <= '0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         load_pos_ff   <= load_pos_in;
         scan_ff       <= scan_in;
         issue_ff      <= issue_in;
         cmp_valid_ff  <= cmp_valid_in;
         cmp_idx_ff    <= cmp_idx_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_SIGNATURES; i++) begin
            len_ff[i] <= '0;
         end
      end else if (len_wr) begin
         len_ff[count_ff[IDX_W-1:0]] <= pos_next;
      end
   end

   always_ff @(posedge clock) begin
      row_ff      <= row_in;
      hold_off_ff <= hold_off_in;
      hold_idx_ff <= hold_idx_in;
      if (emit) begin
         rsp_off_ff  <= emit_off;
         rsp_idx_ff  <= emit_idx;
         rsp_last_ff <= emit_last;
      end
   end

   msbs_sig_ram #(
      .DEPTH (MAX_SIGNATURES),
      .WIDTH (ROW_W),
      .AW    (IDX_W)
   ) u_sig_ram (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (row_next),
      .rd_en   (ram_rd),
      .rd_addr (issue_ff[IDX_W-1:0]),
      .rd_data (ram_rdata)
   );

   msbs_match_unit #(
      .SIG_LEN (MAX_SIG_LEN),
      .LEN_W   (LEN_W)
   ) u_match (
      .clock     (clock),
      .reset     (reset),
      .hist_ctl  (hist_ctl),
      .row       (ram_rdata),
      .len       (cur_len),
      .bytes_hit (bytes_hit)
   );

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_match_offset    = rsp_off_ff;
   assign rsp_signature_index = rsp_idx_ff;
   assign rsp_last            = rsp_last_ff;

endmodule

### sv/msbs_sig_ram.sv
// signature row memory, one row per signature, registered read
module msbs_sig_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 512,
   parameter int AW    = 4
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/msbs_match_unit.sv
// history window of recent data bytes and the shared masked row compare
module msbs_match_unit #(
   parameter int SIG_LEN = 64,
   parameter int LEN_W   = 7
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  msbs_pkg::hist_ctl_type                 hist_ctl,
   input  logic [SIG_LEN*msbs_pkg::BYTE_W-1:0]    row,
   input  logic [LEN_W-1:0]                       len,
   output logic                                   bytes_hit
);
   import msbs_pkg::*;

   localparam int ROW_W = SIG_LEN * BYTE_W;

   // byte j of the window is the data byte j places back from the newest
   logic [ROW_W-1:0]   hist_ff;
   logic [ROW_W-1:0]   hist_in;
   logic [SIG_LEN-1:0] eq;

   always_comb begin
      hist_in = hist_ff;
      if (hist_ctl.clear) begin
         hist_in = '0;
      end else if (hist_ctl.shift) begin
         hist_in = ROW_W'({hist_ff, hist_ctl.data});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff <= '0;
      end else begin
         hist_ff <= hist_in;
      end
   end

   always_comb begin
      for (int j = 0; j < SIG_LEN; j++) begin
         eq[j] = (row[j*BYTE_W +: BYTE_W] == hist_ff[j*BYTE_W +: BYTE_W]) ||
                 !(LEN_W'(j) < len);
      end
   end

   assign bytes_hit = &eq;

endmodule

### sv/msbs_checker.sv
// port-level checks for the scanner core and their bind to it
module msbs_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic [msbs_pkg::MODE_W-1:0]  req_mode,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [msbs_pkg::OFF_W-1:0]   rsp_match_offset,
   input logic [msbs_pkg::SIDX_W-1:0]  rsp_signature_index,
   input logic                         rsp_last
);
   import msbs_pkg::*;

   // a held word keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_match_offset) &&
      $stable(rsp_signature_index) && $stable(rsp_last))
      else $error("rsp word changed while stalled");

   // more matches are still coming, so no new request is taken
   a_busy_until_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("request taken before last match word");

   // a load word gives no result
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_mode == MODE_LOAD) && !rsp_valid |=> !rsp_valid)
      else $error("result after load word");

   // out of reset idle and empty
   a_reset_idle: assert property (@(posedge clock)
      reset |=> req_ready && !rsp_valid)
      else $error("not idle after reset");

endmodule

bind multi_signature_byte_scanner_core msbs_checker u_msbs_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_ready           (req_ready),
   .req_mode            (req_mode),
   .rsp_valid           (rsp_valid),
   .rsp_ready           (rsp_ready),
   .rsp_match_offset    (rsp_match_offset),
   .rsp_signature_index (rsp_signature_index),
   .rsp_last            (rsp_last)
);

### tb/sv/tb_top.sv
// self-checking testbench for multi_signature_byte_scanner_core, directed and random word streams
`timescale 1ns / 1ps
module tb_top;
   import msbs_pkg::*;

   localparam int MAX_SIGS       = 16;
   localparam int SIG_LEN        = 64;
   localparam int BUF_LIMIT      = 16384;
   localparam int RANDOM_ITEMS   = 500;
   localparam int QUIET_CYCLES   = 48;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

   typedef logic [BYTE_W-1:0] byte_q_type[$];

   typedef struct packed {
      logic [OFF_W-1:0]  offset;
      logic [SIDX_W-1:0] index;
      logic              last;
   } match_type;

   logic                clock          = 1'b0;
   logic                reset          = 1'b1;
   logic                req_valid      = 1'b0;
   logic                req_ready;
   logic [MODE_W-1:0]   req_mode       = MODE_LOAD;
   logic [BYTE_W-1:0]   req_byte_value = '0;
   logic                req_sig_end    = 1'b0;
   logic                rsp_valid;
   logic                rsp_ready      = 1'b0;
   logic [OFF_W-1:0]    rsp_match_offset;
   logic [SIDX_W-1:0]   rsp_signature_index;
   logic                rsp_last;

   bit          req_idle_en    = 1'b1;
   bit          rsp_idle_en    = 1'b1;
   int unsigned rsp_hold       = 0;
   int unsigned quiet_count    = 0;
   int unsigned mismatch_count = 0;

   // predictor state
   logic [BYTE_W-1:0] sig_mem [MAX_SIGS][SIG_LEN];
   int unsigned       sig_len [MAX_SIGS] = '{default: 0};
   int unsigned       sig_total = 0;
   int unsigned       load_fill = 0;
   logic [BYTE_W-1:0] window [SIG_LEN] = '{default: '0};
   int unsigned       data_pos = 0;
   match_type         pending_matches[$];

   // signatures as loaded by the stimulus side
   byte_q_type  sig_book [MAX_SIGS];
   int unsigned book_count = 0;

   multi_signature_byte_scanner_core #(
      .MAX_SIGNATURES(MAX_SIGS),
      .MAX_SIG_LEN(SIG_LEN),
      .MAX_BUFFER(BUF_LIMIT)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_mode(req_mode),
      .req_byte_value(req_byte_value),
      .req_sig_end(req_sig_end),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_match_offset(rsp_match_offset),
      .rsp_signature_index(rsp_signature_index),
      .rsp_last(rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void predict_word(input logic [MODE_W-1:0] mode,
                                        input logic [BYTE_W-1:0] value,
                                        input logic end_mark);
      int unsigned len;
      int unsigned hits;
      bit          ok;
      match_type   m;
      case (mode)
         MODE_LOAD: begin
            if (sig_total < MAX_SIGS) begin
               if (load_fill < SIG_LEN) begin
                  sig_mem[sig_total][load_fill] = value;
                  load_fill++;
               end
               if (end_mark) begin
                  sig_len[sig_total] = load_fill;
                  sig_total++;
                  load_fill = 0;
               end
            end
         end
         MODE_NEWBUF: begin
            data_pos = 0;
            foreach (window[i]) window[i] = '0;
         end
         MODE_SCAN: begin
            if (data_pos < BUF_LIMIT) begin
               window[data_pos % SIG_LEN] = value;
               hits = 0;
               for (int s = 0; s < sig_total; s++) begin
                  len = sig_len[s];
                  ok = (len != 0) && (len <= data_pos + 1);
                  for (int k = 0; ok && k < len; k++) begin
                     if (window[(data_pos + SIG_LEN - (len - 1 - k)) % SIG_LEN] !=
                         sig_mem[s][k])
                        ok = 1'b0;
                  end
                  if (ok) begin
                     m.offset = OFF_W'(data_pos + 1 - len);
                     m.index  = SIDX_W'(s);
                     m.last   = 1'b0;
                     pending_matches.push_back(m);
                     hits++;
                  end
               end
               if (hits != 0) pending_matches[pending_matches.size() - 1].last = 1'b1;
               data_pos++;
            end
         end
         default: ;
      endcase
   endfunction

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      mismatch_count++;
      $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
   endtask

   // prediction on accepted words, checking of accepted matches, watchdog
   always @(posedge clock) begin : monitor
      match_type want;
      if (reset) begin
         quiet_count = 0;
      end else begin
         if (req_valid && req_ready) predict_word(req_mode, req_byte_value, req_sig_end);
         if (rsp_valid && rsp_ready) begin
            if (pending_matches.size() == 0) begin
               report_mismatch("unexpected match, index", 32'(rsp_signature_index), 0);
            end else begin
               want = pending_matches.pop_front();
               if (rsp_match_offset !== want.offset)
                  report_mismatch("match_offset", 32'(rsp_match_offset), 32'(want.offset));
               if (rsp_signature_index !== want.index)
                  report_mismatch("signature_index", 32'(rsp_signature_index),
                                  32'(want.index));
               if (rsp_last !== want.last)
                  report_mismatch("last", 32'(rsp_last), 32'(want.last));
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_count = 0;
         else quiet_count++;
         if (quiet_count >= WATCHDOG_LIMIT) begin
            $display("FAIL multi_signature_byte_scanner_core");
            $finish;
         end
      end
   end

   // result side stalls
   always @(posedge clock) begin : rsp_pacing
      int unsigned stall;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_hold = 0;
      end else if (rsp_hold != 0) begin
         rsp_ready <= (rsp_hold == 1);
         rsp_hold = rsp_hold - 1;
      end else if (!rsp_ready || rsp_valid) begin
         stall = rsp_idle_en ? $urandom_range(0, 8) : 0;
         rsp_ready <= (stall == 0);
         rsp_hold = stall;
      end
   end

   task automatic send_word(input logic [MODE_W-1:0] mode, input logic [BYTE_W-1:0] value,
                            input logic end_mark);
      int unsigned gap;
      gap = req_idle_en ? $urandom_range(0, 8) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_mode       <= mode;
      req_byte_value <= value;
      req_sig_end    <= end_mark;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_matches.size() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   function automatic void note_signature(input byte_q_type bytes);
      if (book_count < MAX_SIGS) begin
         sig_book[book_count] = {};
         foreach (bytes[i]) if (i < SIG_LEN) sig_book[book_count].push_back(bytes[i]);
         book_count++;
      end
   endfunction

   task automatic load_signature(input byte_q_type bytes);
      foreach (bytes[i]) send_word(MODE_LOAD, bytes[i], i == bytes.size() - 1);
      note_signature(bytes);
   endtask

   task automatic scan_bytes(input byte_q_type bytes);
      foreach (bytes[i]) send_word(MODE_SCAN, bytes[i], 1'($urandom_range(0, 1)));
   endtask

   function automatic logic [BYTE_W-1:0] pattern_byte();
      case ($urandom_range(0, 4))
         0: return 8'h00;
         1: return 8'hFF;
         2: return 8'h5A;
         3: return 8'hA5;
         default: return BYTE_W'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic test_empty_table();
      byte_q_type d;
      d = {8'h00, 8'hFF, 8'h5A};
      send_word(MODE_NEWBUF, 8'h00, 1'b0);
      scan_bytes(d);
      send_word(MODE_UNUSED, 8'hFF, 1'b1);
      send_word(MODE_UNUSED, 8'h00, 1'b0);
      wait_idle();
   endtask

   task automatic test_open_signature();
      byte_q_type d;
      d = {8'hFF, 8'h00};
      send_word(MODE_LOAD, 8'hFF, 1'b0);
      send_word(MODE_NEWBUF, 8'h00, 1'b0);
      // not closed yet, so no match
      scan_bytes(d);
      send_word(MODE_LOAD, 8'h00, 1'b1);
      note_signature(d);
      send_word(MODE_NEWBUF, 8'hFF, 1'b1);
      scan_bytes(d);
      wait_idle();
   endtask

   task automatic test_short_data();
      byte_q_type d;
      d = {8'h00, 8'h00, 8'h00};
      load_signature(d);
      send_word(MODE_NEWBUF, 8'h00, 1'b0);
      d = {8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
      scan_bytes(d);
      wait_idle();
   endtask

   task automatic test_overlong_signature();
      byte_q_type d;
      repeat (70) d.push_back(BYTE_W'($urandom_range(0, 255)));
      load_signature(d);
      send_word(MODE_NEWBUF, 8'h00, 1'b0);
      d = {8'h11, 8'h22, 8'h33};
      scan_bytes(d);
      scan_bytes(sig_book[book_count - 1]);
      wait_idle();
   endtask

   task automatic test_shared_suffix();
      byte_q_type d;
      d = {8'h5A};
      load_signature(d);
      d = {8'hA5, 8'h5A};
      load_signature(d);
      d = {8'h5A};
      load_signature(d);
      send_word(MODE_NEWBUF, 8'h00, 1'b0);
      d = {8'hA5, 8'h5A, 8'h5A};
      scan_bytes(d);
      wait_idle();
   endtask

   task automatic test_random_traffic();
      byte_q_type  d;
      int unsigned sent;
      int unsigned n;
      int unsigned s;
      int unsigned first;
      int unsigned pick;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         req_idle_en = ($urandom_range(0, 3) != 0);
         rsp_idle_en = ($urandom_range(0, 3) != 0);
         pick = $urandom_range(0, 9);
         d = {};
         if (pick < 3) begin
            if (book_count != 0 && $urandom_range(0, 1) == 1) begin
               s = $urandom_range(0, book_count - 1);
               first = $urandom_range(0, sig_book[s].size() - 1);
               for (int k = first; k < sig_book[s].size(); k++) d.push_back(sig_book[s][k]);
            end else begin
               n = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 72) : $urandom_range(1, 4);
               repeat (n) d.push_back(pattern_byte());
            end
            if (book_count < MAX_SIGS) sent += d.size();
            load_signature(d);
         end else if (pick < 9) begin
            if ($urandom_range(0, 2) == 0) begin
               send_word(MODE_NEWBUF, BYTE_W'($urandom_range(0, 255)),
                         1'($urandom_range(0, 1)));
               sent++;
            end
            n = $urandom_range(2, 30);
            repeat (n) begin
               if (book_count != 0 && $urandom_range(0, 3) == 0) begin
                  s = $urandom_range(0, book_count - 1);
                  for (int k = 0; k < sig_book[s].size(); k++) d.push_back(sig_book[s][k]);
               end else begin
                  d.push_back(pattern_byte());
               end
            end
            scan_bytes(d);
            sent += d.size();
         end else begin
            send_word(MODE_UNUSED, BYTE_W'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)));
            send_word(MODE_NEWBUF, BYTE_W'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)));
            sent++;
         end
      end
      wait_idle();
   endtask

   task automatic test_table_full();
      byte_q_type d;
      d = {8'h5A};
      while (book_count < MAX_SIGS) load_signature(d);
      // table is full, these bytes are dropped
      d = {8'h3C, 8'hC3};
      load_signature(d);
      send_word(MODE_NEWBUF, 8'h00, 1'b0);
      d = {8'h3C, 8'hC3, 8'h5A, 8'hA5, 8'h5A};
      scan_bytes(d);
      wait_idle();
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_empty_table();
      test_open_signature();
      test_short_data();
      test_overlong_signature();
      test_shared_suffix();
      test_random_traffic();
      test_table_full();
      if (mismatch_count == 0) begin
         $display("PASS multi_signature_byte_scanner_core");
      end else begin
         $display("FAIL multi_signature_byte_scanner_core");
      end
      $finish;
   end

endmodule
